// ----- src/indexed_insert_extract_list_defines.svh -----
`ifndef INDEXED_INSERT_EXTRACT_LIST_DEFINES_SVH
`define INDEXED_INSERT_EXTRACT_LIST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IIEL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iiel check failed");

// next-cycle implication, checked outside reset
`define IIEL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iiel check failed");

`endif

// ----- src/iiel_pkg.sv -----
package iiel_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int CNT_OUT_W = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_EXTRACT   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic [STAT_W-1:0]        status;
    logic [CNT_OUT_W-1:0]     count;
  } out_word_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_DONE
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

endpackage

// ----- src/indexed_insert_extract_list.sv -----
// Ordered list of up to CAPACITY signed 32-bit words with push, pop, insert
// and extract at any position. A command word is taken at a rising edge with
// start high and busy low. Its result is on result during the cycle that
// follows the next rising edge, with done high for exactly that one cycle.
// The receiver cannot stall: capture result whenever done is high. A new
// command may be issued in the done cycle, so the block takes a new command
// while a result is shown but not while one executes: the command is first
// registered, then every list cell is updated in parallel and the result
// register loads. No clearing pass after reset.
module indexed_insert_extract_list (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  iiel_pkg::in_word_t  command,
  output iiel_pkg::out_word_t result
);

  iiel_pkg::ctl_cmd_t cmd;

  iiel_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  iiel_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .command (command),
    .result  (result)
  );

endmodule

// ----- src/iiel_ctrl.sv -----
`include "indexed_insert_extract_list_defines.svh"

module iiel_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output iiel_pkg::ctl_cmd_t cmd
);

  iiel_pkg::ctl_state_t state;
  iiel_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iiel_pkg::CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state)
      iiel_pkg::CTL_IDLE: begin
        cmd.load = start;
        if (start) state_next = iiel_pkg::CTL_EXEC;
      end
      iiel_pkg::CTL_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = iiel_pkg::CTL_DONE;
      end
      iiel_pkg::CTL_DONE: begin
        done       = 1'b1;
        cmd.load   = start;
        state_next = start ? iiel_pkg::CTL_EXEC : iiel_pkg::CTL_IDLE;
      end
      default: begin
        state_next = iiel_pkg::CTL_IDLE;
      end
    endcase
  end

  `IIEL_ASSERT_NEXT(a_accept_then_exec, start && !busy, cmd.exec)
  `IIEL_ASSERT_NEXT(a_exec_then_done, cmd.exec, done && !cmd.exec)
  `IIEL_ASSERT_NOW(a_done_after_exec, done, $past(cmd.exec))

endmodule

// ----- src/iiel_datapath.sv -----
`include "indexed_insert_extract_list_defines.svh"

module iiel_datapath (
  input  logic                clk,
  input  logic                rst,
  input  iiel_pkg::ctl_cmd_t  cmd,
  input  iiel_pkg::in_word_t  command,
  output iiel_pkg::out_word_t result
);

  iiel_pkg::in_word_t                 cmd_reg;
  logic signed [iiel_pkg::DATA_W-1:0] cells [iiel_pkg::CAPACITY];
  logic signed [iiel_pkg::DATA_W-1:0] cells_next [iiel_pkg::CAPACITY];
  logic [iiel_pkg::CNT_W-1:0]         count;
  logic [iiel_pkg::CNT_W-1:0]         count_next;
  logic signed [iiel_pkg::DATA_W-1:0] removed;
  logic [iiel_pkg::STAT_W-1:0]        status;
  logic [iiel_pkg::STAT_W-1:0]        status_calc;

  logic [iiel_pkg::CMP_W-1:0] cnt_x;
  logic [iiel_pkg::CMP_W-1:0] pos_x;
  logic [iiel_pkg::CMP_W-1:0] eff_pos;
  logic [iiel_pkg::IDX_W-1:0] idx;
  logic                       is_ins;
  logic                       is_rem;
  logic                       ins_ok;
  logic                       rem_ok;
  logic                       full;

  always_ff @(posedge clk) begin
    if (cmd.load) cmd_reg <= command;
  end

  always_comb begin
    cnt_x   = iiel_pkg::CMP_W'(count);
    pos_x   = iiel_pkg::CMP_W'(cmd_reg.position);
    eff_pos = '0;
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    unique case (cmd_reg.mode)
      iiel_pkg::MODE_PUSH_HEAD: begin is_ins = 1'b1; eff_pos = '0; end
      iiel_pkg::MODE_PUSH_TAIL: begin is_ins = 1'b1; eff_pos = cnt_x; end
      iiel_pkg::MODE_INSERT:    begin is_ins = 1'b1; eff_pos = pos_x; end
      iiel_pkg::MODE_POP_HEAD:  begin is_rem = 1'b1; eff_pos = '0; end
      iiel_pkg::MODE_POP_TAIL:  begin is_rem = 1'b1; eff_pos = cnt_x - 1'b1; end
      iiel_pkg::MODE_EXTRACT:   begin is_rem = 1'b1; eff_pos = pos_x; end
      default: begin end
    endcase
    full   = (count >= iiel_pkg::CNT_W'(iiel_pkg::CAPACITY));
    ins_ok = is_ins && (eff_pos <= cnt_x) && !full;
    rem_ok = is_rem && (count != '0) && (eff_pos < cnt_x);
    idx    = eff_pos[iiel_pkg::IDX_W-1:0];
    if (is_ins) begin
      if (eff_pos > cnt_x)  status_calc = iiel_pkg::ST_INVALID;
      else if (full)        status_calc = iiel_pkg::ST_FULL;
      else                  status_calc = iiel_pkg::ST_OK;
    end else if (rem_ok) begin
      status_calc = iiel_pkg::ST_OK;
    end else begin
      status_calc = iiel_pkg::ST_INVALID;
    end
    count_next = count;
    if (ins_ok) count_next = count + 1'b1;
    else if (rem_ok) count_next = count - 1'b1;
  end

  for (genvar g = 0; g < iiel_pkg::CAPACITY; g++) begin : g_cell
    logic signed [iiel_pkg::DATA_W-1:0] from_prev;
    logic signed [iiel_pkg::DATA_W-1:0] from_next;
    logic [iiel_pkg::CMP_W-1:0]         here;

    if (g == 0) begin : g_first
      assign from_prev = cells[g];
    end else begin : g_mid
      assign from_prev = cells[g-1];
    end
    if (g == iiel_pkg::CAPACITY - 1) begin : g_last
      assign from_next = cells[g];
    end else begin : g_body
      assign from_next = cells[g+1];
    end
    assign here = iiel_pkg::CMP_W'(g);

    always_comb begin
      cells_next[g] = cells[g];
      if (ins_ok) begin
        if (here == eff_pos)     cells_next[g] = cmd_reg.value;
        else if (here > eff_pos) cells_next[g] = from_prev;
      end else if (rem_ok) begin
        if (here >= eff_pos)     cells_next[g] = from_next;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) cells[g] <= cells_next[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      removed <= rem_ok ? cells[idx] : '0;
      status  <= status_calc;
    end
  end

  assign result.removed_value = removed;
  assign result.status        = status;
  assign result.count         = iiel_pkg::CNT_OUT_W'(count);

  `IIEL_ASSERT_NOW(a_count_bound, 1'b1, count <= iiel_pkg::CNT_W'(iiel_pkg::CAPACITY))
  `IIEL_ASSERT_NEXT(a_insert_grows, cmd.exec && ins_ok, count == $past(count) + 1'b1)
  `IIEL_ASSERT_NEXT(a_fail_holds, cmd.exec && !ins_ok && !rem_ok,
                    count == $past(count) && status != iiel_pkg::ST_OK)

endmodule

// ----- tb/tb_indexed_insert_extract_list.sv -----
module tb_indexed_insert_extract_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [iiel_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [iiel_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam logic [iiel_pkg::DATA_W-1:0] MAX_VAL = 32'h7FFF_FFFF;
  localparam logic [iiel_pkg::DATA_W-1:0] MIN_VAL = 32'h8000_0000;
  localparam logic [iiel_pkg::DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 535;

  typedef struct packed {
    iiel_pkg::in_word_t  cmd;
    logic [3:0]          reps;
    logic                typed;
    iiel_pkg::out_word_t want;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;
  localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
    {iiel_pkg::MODE_POP_HEAD,  5'd0,  32'd0,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd0},
    {iiel_pkg::MODE_POP_TAIL,  5'd0,  32'd0,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd0},
    {iiel_pkg::MODE_EXTRACT,   5'd0,  32'd0,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd0},
    {iiel_pkg::MODE_INSERT,    5'd1,  32'd5,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd0},
    {MODE_SPARE_6,             5'd0,  32'd9,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd0},
    {MODE_SPARE_7,             5'd31, ALL_ONES, 4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd0},
    {iiel_pkg::MODE_INSERT,    5'd0,  MAX_VAL,  4'd1, 1'b1, 32'd0, iiel_pkg::ST_OK,      5'd1},
    {iiel_pkg::MODE_PUSH_HEAD, 5'd0,  MIN_VAL,  4'd1, 1'b1, 32'd0, iiel_pkg::ST_OK,      5'd2},
    {iiel_pkg::MODE_PUSH_TAIL, 5'd0,  ALL_ONES, 4'd1, 1'b1, 32'd0, iiel_pkg::ST_OK,      5'd3},
    {iiel_pkg::MODE_INSERT,    5'd3,  32'd1,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_OK,      5'd4},
    {iiel_pkg::MODE_INSERT,    5'd5,  32'd7,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd4},
    {iiel_pkg::MODE_EXTRACT,   5'd4,  32'd0,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd4},
    {iiel_pkg::MODE_EXTRACT,   5'd1,  32'd0,    4'd1, 1'b0, 32'd0, iiel_pkg::ST_OK,      5'd0},
    {iiel_pkg::MODE_POP_TAIL,  5'd0,  32'd0,    4'd1, 1'b0, 32'd0, iiel_pkg::ST_OK,      5'd0},
    {iiel_pkg::MODE_POP_HEAD,  5'd0,  32'd0,    4'd1, 1'b0, 32'd0, iiel_pkg::ST_OK,      5'd0},
    {iiel_pkg::MODE_PUSH_TAIL, 5'd0,  32'h5A5A5A5A, 4'd15, 1'b0, 32'd0, iiel_pkg::ST_OK, 5'd0},
    {iiel_pkg::MODE_PUSH_HEAD, 5'd0,  32'd3,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_FULL,    5'd16},
    {iiel_pkg::MODE_INSERT,    5'd16, 32'd3,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_FULL,    5'd16},
    {iiel_pkg::MODE_INSERT,    5'd17, 32'd3,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd16},
    {iiel_pkg::MODE_INSERT,    5'd31, 32'd3,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd16},
    {iiel_pkg::MODE_EXTRACT,   5'd15, 32'd0,    4'd1, 1'b0, 32'd0, iiel_pkg::ST_OK,      5'd0},
    {iiel_pkg::MODE_EXTRACT,   5'd31, 32'd0,    4'd1, 1'b1, 32'd0, iiel_pkg::ST_INVALID, 5'd15}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                done;
  iiel_pkg::in_word_t  command = '0;
  iiel_pkg::out_word_t result;

  logic signed [iiel_pkg::DATA_W-1:0] cells[$];
  iiel_pkg::out_word_t due_results[$];
  int          errors = 0;
  int          idle_pct = 35;
  int unsigned cycle_count = 0;

  indexed_insert_extract_list dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .done(done),
    .command(command),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL indexed_insert_extract_list");
      $finish;
    end
  end

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  function automatic logic [iiel_pkg::STAT_W-1:0] store_word(
      input int pos, input logic signed [iiel_pkg::DATA_W-1:0] v);
    if (pos > cells.size()) return iiel_pkg::ST_INVALID;
    if (cells.size() >= iiel_pkg::CAPACITY) return iiel_pkg::ST_FULL;
    cells.insert(pos, v);
    return iiel_pkg::ST_OK;
  endfunction

  function automatic logic [iiel_pkg::STAT_W-1:0] pull_word(
      input int pos, output logic signed [iiel_pkg::DATA_W-1:0] v);
    v = '0;
    if (cells.size() == 0 || pos >= cells.size()) return iiel_pkg::ST_INVALID;
    v = cells[pos];
    cells.delete(pos);
    return iiel_pkg::ST_OK;
  endfunction

  function automatic iiel_pkg::out_word_t list_outcome(input iiel_pkg::in_word_t w);
    iiel_pkg::out_word_t r;
    logic signed [iiel_pkg::DATA_W-1:0] got;
    r = '0;
    got = '0;
    case (w.mode)
      iiel_pkg::MODE_PUSH_HEAD: r.status = store_word(0, w.value);
      iiel_pkg::MODE_PUSH_TAIL: r.status = store_word(cells.size(), w.value);
      iiel_pkg::MODE_INSERT:    r.status = store_word(int'(w.position), w.value);
      iiel_pkg::MODE_POP_HEAD:  r.status = pull_word(0, got);
      iiel_pkg::MODE_POP_TAIL:  r.status = pull_word(cells.size() - 1, got);
      iiel_pkg::MODE_EXTRACT:   r.status = pull_word(int'(w.position), got);
      default:                  r.status = iiel_pkg::ST_INVALID;
    endcase
    r.removed_value = got;
    r.count = iiel_pkg::CNT_OUT_W'(cells.size());
    return r;
  endfunction

  function automatic iiel_pkg::in_word_t rand_word(input bit growing);
    iiel_pkg::in_word_t w;
    int n;
    int r;
    bit adding;
    n = cells.size();
    r = $urandom_range(99);
    w.value = $urandom;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: w.value = MAX_VAL;
        1: w.value = MIN_VAL;
        2: w.value = '0;
        default: w.value = ALL_ONES;
      endcase
    end
    adding = growing ? (r < 70) : (r < 33);
    if (r < 3) begin
      w.mode = r[0] ? MODE_SPARE_7 : MODE_SPARE_6;
    end else if (adding) begin
      case ($urandom_range(2))
        0: w.mode = iiel_pkg::MODE_PUSH_HEAD;
        1: w.mode = iiel_pkg::MODE_PUSH_TAIL;
        default: w.mode = iiel_pkg::MODE_INSERT;
      endcase
    end else begin
      case ($urandom_range(2))
        0: w.mode = iiel_pkg::MODE_POP_HEAD;
        1: w.mode = iiel_pkg::MODE_POP_TAIL;
        default: w.mode = iiel_pkg::MODE_EXTRACT;
      endcase
    end
    if ($urandom_range(7) == 0) begin
      w.position = iiel_pkg::POS_W'($urandom_range(31));
    end else if (w.mode == iiel_pkg::MODE_INSERT) begin
      w.position = iiel_pkg::POS_W'($urandom_range(n));
    end else if (w.mode == iiel_pkg::MODE_EXTRACT && n > 0) begin
      w.position = iiel_pkg::POS_W'($urandom_range(n - 1));
    end else begin
      w.position = iiel_pkg::POS_W'($urandom_range(31));
    end
    return w;
  endfunction

  task automatic issue(input iiel_pkg::in_word_t w, input bit typed,
                       input iiel_pkg::out_word_t want);
    iiel_pkg::out_word_t calc;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= w;
    do @(posedge clk); while (busy);
    calc = list_outcome(w);
    due_results.push_back(typed ? want : calc);
  endtask

  always @(posedge clk) begin : check_results
    iiel_pkg::out_word_t want;
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        log_error($sformatf("unexpected word: removed=%0d status=%0d count=%0d",
                            result.removed_value, result.status, result.count));
      end else begin
        want = due_results.pop_front();
        if (result.removed_value !== want.removed_value || result.status !== want.status ||
            result.count !== want.count) begin
          log_error($sformatf({"mismatch: exp removed=%0d status=%0d count=%0d, ",
                               "got removed=%0d status=%0d count=%0d"},
                              want.removed_value, want.status, want.count,
                              result.removed_value, result.status, result.count));
        end
      end
    end
  end

  initial begin
    bit growing;
    growing = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      for (int k = 0; k < PLAN[i].reps; k++) begin
        issue(PLAN[i].cmd, PLAN[i].typed, PLAN[i].want);
      end
    end

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 35 : (p == 1) ? 81 : 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (cells.size() == iiel_pkg::CAPACITY && $urandom_range(2) == 0) growing = 1'b0;
        else if (cells.size() == 0 && $urandom_range(2) == 0) growing = 1'b1;
        else if ($urandom_range(49) == 0) growing = !growing;
        issue(rand_word(growing), 1'b0, '0);
      end
      // hold off until every word is back
      start <= 1'b0;
      do @(posedge clk); while (due_results.size() != 0);
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("PASS indexed_insert_extract_list");
    end else begin
      $display("FAIL indexed_insert_extract_list");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/iiel_pkg.sv
src/iiel_ctrl.sv
src/iiel_datapath.sv
src/indexed_insert_extract_list.sv
tb/tb_indexed_insert_extract_list.sv
